>>> src/hcbd_pkg.sv
// package: shared types, codes and helpers of the chunked body decoder
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam logic [7:0]  CHAR_CR        = 8'h0d;
  localparam logic [7:0]  CHAR_LF        = 8'h0a;
  localparam int          HEX_DIGIT_BITS = 4;
  localparam int          BODY_LEN_BITS  = 32;
  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  typedef enum logic [3:0] {
    PH_SIZE    = 4'd0,
    PH_SIZE_LF = 4'd1,
    PH_DATA    = 4'd2,
    PH_DATA_CR = 4'd3,
    PH_DATA_LF = 4'd4,
    PH_SKIP1   = 4'd5,
    PH_SKIP2   = 4'd6,
    PH_DONE    = 4'd7,
    PH_BAD     = 4'd8,
    PH_BIG     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_BAD_REQ  = 2'd2,
    ST_TOO_BIG  = 2'd3
  } status_t;

  typedef struct packed {
    logic       new_message;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       has_data;
    logic [7:0] body_byte;
    status_t    status;
  } out_item_t;

  // input register contents handed to the decode stage
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic                      ok;
    logic [HEX_DIGIT_BITS-1:0] digit;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.digit = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.digit = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic status_t status_of(input phase_t ph);
    status_t s;
    case (ph)
      PH_DONE: s = ST_COMPLETE;
      PH_BAD:  s = ST_BAD_REQ;
      PH_BIG:  s = ST_TOO_BIG;
      default: s = ST_PROGRESS;
    endcase
    return s;
  endfunction

endpackage

>>> src/hcbd_ifs.sv
// interfaces: byte request channel, result channel and config write channel
`timescale 1ns / 1ps

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       new_message;
  logic [7:0] data_byte;
  modport source (output valid, output new_message, output data_byte, input ready);
  modport sink (input valid, input new_message, input data_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic       has_data;
  logic [7:0] body_byte;
  logic [1:0] status;
  modport source (output valid, output has_data, output body_byte, output status,
                  input ready);
  modport sink (input valid, input has_data, input body_byte, input status,
                output ready);
endinterface

interface hcbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/hcbd_in_stage.sv
// input register: holds one accepted byte request until the decode stage takes it
`timescale 1ns / 1ps

module hcbd_in_stage
  import hcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hcbd_in_if.sink    in_ch,
  input  logic       take,
  output stage_t     s1
);

  logic     valid_r;
  in_item_t item_r;
  logic     accept;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.new_message <= in_ch.new_message;
      item_r.data_byte   <= in_ch.data_byte;
    end
  end

  assign s1.valid = valid_r;
  assign s1.item  = item_r;

endmodule

>>> src/hcbd_core.sv
// decode stage: chunk framing state machine, size and total counters, result register
`timescale 1ns / 1ps

module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stage_t                   s1,
  input  logic [BODY_LEN_BITS-1:0] max_body_length,
  hcbd_out_if.source               out_ch,
  output logic                     take
);

  localparam int ACC_BITS = SIZE_BITS + 1;
  localparam int SUM_BITS = ((SIZE_BITS > BODY_LEN_BITS) ? SIZE_BITS : BODY_LEN_BITS) + 1;
  localparam logic [ACC_BITS-1:0] ACC_SAT = ACC_BITS'(1) << SIZE_BITS;

  phase_t                   phase_r, phase_nxt, phase_b;
  logic [ACC_BITS-1:0]      acc_r, acc_nxt, acc_b;
  logic                     saw_r, saw_nxt, saw_b;
  logic [BODY_LEN_BITS-1:0] rem_r, rem_nxt, rem_b, rem_dec;
  logic [BODY_LEN_BITS-1:0] total_r, total_nxt, total_b;
  logic [SUM_BITS-1:0]      sum;
  hex_t                     hv;
  logic [7:0]               c;

  logic      out_valid_r;
  out_item_t out_item_r, res;

  assign take = s1.valid && (!out_valid_r || out_ch.ready);
  assign c    = s1.item.data_byte;
  assign hv   = hex_value(c);

  // new_message wipes the framing state before the byte is looked at
  always_comb begin
    if (s1.item.new_message) begin
      phase_b = PH_SIZE;
      acc_b   = '0;
      saw_b   = 1'b0;
      rem_b   = '0;
      total_b = '0;
    end else begin
      phase_b = phase_r;
      acc_b   = acc_r;
      saw_b   = saw_r;
      rem_b   = rem_r;
      total_b = total_r;
    end
  end

  assign sum     = SUM_BITS'(total_b) + SUM_BITS'(acc_b);
  assign rem_dec = (rem_b != '0) ? rem_b - BODY_LEN_BITS'(1) : rem_b;

  // next state
  always_comb begin
    phase_nxt = phase_b;
    acc_nxt   = acc_b;
    saw_nxt   = saw_b;
    rem_nxt   = rem_b;
    total_nxt = total_b;
    case (phase_b)
      PH_SIZE: begin
        if (c == CHAR_CR) begin
          phase_nxt = PH_SIZE_LF;
        end else if (!hv.ok) begin
          phase_nxt = PH_BAD;
        end else begin
          saw_nxt = 1'b1;
          // saturate once another digit would reach the size limit
          if (|acc_b[ACC_BITS-1:SIZE_BITS-HEX_DIGIT_BITS]) begin
            acc_nxt = ACC_SAT;
          end else begin
            acc_nxt = {acc_b[ACC_BITS-HEX_DIGIT_BITS-1:0], hv.digit};
          end
        end
      end
      PH_SIZE_LF: begin
        if (c != CHAR_LF || !saw_b || acc_b[SIZE_BITS]) begin
          phase_nxt = PH_BAD;
        end else if (acc_b == '0) begin
          phase_nxt = PH_SKIP1;
        end else if (sum > SUM_BITS'(max_body_length)) begin
          phase_nxt = PH_BIG;
        end else begin
          rem_nxt   = BODY_LEN_BITS'(acc_b);
          total_nxt = BODY_LEN_BITS'(sum);
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_DATA_CR;
        end
      end
      PH_DATA_CR: phase_nxt = (c == CHAR_CR) ? PH_DATA_LF : PH_BAD;
      PH_DATA_LF: begin
        if (c == CHAR_LF) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
          saw_nxt   = 1'b0;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_SKIP1: phase_nxt = PH_SKIP2;
      PH_SKIP2: phase_nxt = PH_DONE;
      PH_DONE, PH_BAD, PH_BIG: phase_nxt = phase_b;
      default: phase_nxt = PH_BAD;
    endcase
  end

  // outputs
  always_comb begin
    res.has_data  = (phase_b == PH_DATA);
    res.body_byte = (phase_b == PH_DATA) ? c : 8'h00;
    res.status    = status_of(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      acc_r       <= '0;
      saw_r       <= 1'b0;
      rem_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        acc_r       <= acc_nxt;
        saw_r       <= saw_nxt;
        rem_r       <= rem_nxt;
        total_r     <= total_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.has_data  = out_item_r.has_data;
  assign out_ch.body_byte = out_item_r.body_byte;
  assign out_ch.status    = out_item_r.status;

endmodule

>>> src/http_chunked_body_decoder_unit.sv
// top level: chunked transfer body decoder with config register
// path: a request passes the input register, then the result register
// throughput: one byte request per cycle while results are taken, set by the single decode stage
// a waiting result stalls the decode stage, the input register holds one more request
// reset: synchronous rst_n clears framing state and channels, max_body_length to 1048576
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  hcbd_in_if.sink     in_ch,
  hcbd_out_if.source  out_ch,
  hcbd_cfg_if.sink    cfg_ch
);

  // configured body limit; the user must write it only while idle, the block does not enforce this
  logic [BODY_LEN_BITS-1:0] max_body_r;
  stage_t                   s1;
  logic                     take;

  // config writes always go through
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
    end else if (cfg_ch.valid) begin
      max_body_r <= cfg_ch.data;
    end
  end

  // input register: one byte request deep, refills as the decode stage drains it
  hcbd_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .s1    (s1)
  );

  // decode stage: framing state machine plus result register
  hcbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1              (s1),
    .max_body_length (max_body_r),
    .out_ch          (out_ch),
    .take            (take)
  );

endmodule

>>> src/hcbd_checker.sv
// checker: port-level properties of the decoder, bound to the top level
`timescale 1ns / 1ps

module hcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       has_data,
  input logic [7:0] body_byte,
  input logic [1:0] status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(has_data) && $stable(body_byte)
      && $stable(status))
    else $error("result changed while stalled");

  // a data byte only comes while the body is still in progress
  a_data_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_data |-> status == 2'd0)
    else $error("data byte with terminal status");

  // no data means a zero byte
  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_data |-> body_byte == 8'h00)
    else $error("nonzero byte without data");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .has_data  (out_ch.has_data),
  .body_byte (out_ch.body_byte),
  .status    (out_ch.status)
);

>>> dv/tb.sv
// testbench: directed and random chunked byte streams through the decoder, checked by a decoder model
`timescale 1ns / 1ps

module tb
  import hcbd_pkg::*;
();

  localparam int          HALF_PERIOD  = 5;
  localparam int          RESET_CYCLES = 10;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PRINT_LIMIT  = 40;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [32:0] SIZE_LIMIT   = 33'h1_0000_0000;

  logic clk = 1'b0;
  logic rst_n;

  hcbd_in_if  in_ch ();
  hcbd_out_if out_ch ();
  hcbd_cfg_if cfg_ch ();

  http_chunked_body_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // decoder model state, advanced once per accepted request
  phase_t      dec_phase;
  logic [32:0] size_acc;
  logic        saw_digit;
  logic [31:0] bytes_left;
  logic [31:0] body_total;
  logic [31:0] max_body;

  out_item_t due_decodes[$];
  out_item_t want;
  int        errors       = 0;
  int        cycles       = 0;
  int        in_idle_pct  = 0;
  int        out_idle_pct = 0;
  int        stall_left   = 0;
  bit        hold_req     = 1'b0;
  bit        hold_seen    = 1'b0;
  bit        offering     = 1'b0;

  function automatic void clear_framing();
    dec_phase  = PH_SIZE;
    size_acc   = '0;
    saw_digit  = 1'b0;
    bytes_left = '0;
    body_total = '0;
  endfunction

  function automatic out_item_t chunk_decode(input in_item_t req);
    out_item_t  res;
    logic [7:0] c;
    logic [3:0] nibble;
    logic       is_hex;
    res.has_data  = 1'b0;
    res.body_byte = '0;
    c      = req.data_byte;
    is_hex = 1'b1;
    nibble = '0;
    if (c >= "0" && c <= "9") begin
      nibble = c[3:0];
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      nibble = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
    if (req.new_message) clear_framing();
    case (dec_phase)
      PH_SIZE: begin
        if (c == CHAR_CR) begin
          dec_phase = PH_SIZE_LF;
        end else if (!is_hex) begin
          dec_phase = PH_BAD;
        end else begin
          saw_digit = 1'b1;
          // accumulator sticks at the limit once another digit would overflow it
          if (size_acc >= (SIZE_LIMIT >> 4)) size_acc = SIZE_LIMIT;
          else size_acc = (size_acc << 4) | 33'(nibble);
        end
      end
      PH_SIZE_LF: begin
        if (c != CHAR_LF || !saw_digit || size_acc >= SIZE_LIMIT) begin
          dec_phase = PH_BAD;
        end else if (size_acc == 0) begin
          dec_phase = PH_SKIP1;
        end else if ({2'b0, body_total} + {1'b0, size_acc} > {2'b0, max_body}) begin
          dec_phase = PH_BIG;
        end else begin
          bytes_left = size_acc[31:0];
          body_total = body_total + size_acc[31:0];
          dec_phase  = PH_DATA;
        end
      end
      PH_DATA: begin
        res.has_data  = 1'b1;
        res.body_byte = c;
        if (bytes_left > 0) bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) dec_phase = PH_DATA_CR;
      end
      PH_DATA_CR: dec_phase = (c == CHAR_CR) ? PH_DATA_LF : PH_BAD;
      PH_DATA_LF: begin
        if (c == CHAR_LF) begin
          dec_phase = PH_SIZE;
          size_acc  = '0;
          saw_digit = 1'b0;
        end else begin
          dec_phase = PH_BAD;
        end
      end
      PH_SKIP1: dec_phase = PH_SKIP2;
      PH_SKIP2: dec_phase = PH_DONE;
      PH_DONE, PH_BAD, PH_BIG: ;
      default: dec_phase = PH_BAD;
    endcase
    case (dec_phase)
      PH_DONE: res.status = ST_COMPLETE;
      PH_BAD:  res.status = ST_BAD_REQ;
      PH_BIG:  res.status = ST_TOO_BIG;
      default: res.status = ST_PROGRESS;
    endcase
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input int exp_val, input int act_val);
    if (errors < PRINT_LIMIT)
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_val, act_val);
    errors++;
  endfunction

  // result side: every accepted result is matched against the oldest decode due
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_decodes.size() == 0) begin
        flag_mismatch("unrequested result, status", -1, out_ch.status);
      end else begin
        want = due_decodes.pop_front();
        if (out_ch.has_data !== want.has_data)
          flag_mismatch("has_data", want.has_data, out_ch.has_data);
        if (out_ch.body_byte !== want.body_byte)
          flag_mismatch("body_byte", want.body_byte, out_ch.body_byte);
        if (out_ch.status !== want.status)
          flag_mismatch("status", want.status, out_ch.status);
      end
    end
  end

  // result ready: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      stall_left   <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic nm, input logic [7:0] b);
    in_item_t req;
    req.new_message = nm;
    req.data_byte   = b;
    in_ch.valid       <= 1'b1;
    in_ch.new_message <= nm;
    in_ch.data_byte   <= b;
    offering = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    due_decodes.insert(due_decodes.size(), chunk_decode(req));
    // each following cycle idles with the set odds
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
  endtask

  // size line: digits then CR LF, new_message on its first byte when asked
  task automatic send_line(input logic nm, input string digits);
    for (int i = 0; i < digits.len(); i++) send_request(nm && i == 0, digits[i]);
    send_request(nm && digits.len() == 0, CHAR_CR);
    send_request(1'b0, CHAR_LF);
  endtask

  task automatic drain_results();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (due_decodes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max_body(input logic [31:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    max_body = value;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 10) return 8'("0") + 8'(d);
    return ($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(d) - 8'd10;
  endfunction

  // one body: a few chunks and the closing zero chunk, sometimes damaged or cut short
  task automatic send_random_body(output int sent);
    logic [7:0]  encoded[$];
    logic [39:0] chunk_len;
    int          chunks, ndig, roll, cut;
    bit          truncated;
    truncated = 1'b0;
    if ($urandom_range(99) < 6) begin
      // raw noise with random new_message bits
      sent = $urandom_range(1, 6);
      repeat (sent) send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
      return;
    end
    chunks = $urandom_range(0, 3);
    for (int ci = 0; ci < chunks; ci++) begin
      roll = $urandom_range(99);
      if (roll < 80) chunk_len = 40'($urandom_range(1, 16));
      else if (roll < 94) chunk_len = 40'($urandom_range(17, 60));
      else if (roll < 97) chunk_len = {8'h00, $urandom};
      else chunk_len = {8'($urandom_range(1, 255)), $urandom};
      ndig = 1;
      for (int k = 1; k < 10; k++) if ((chunk_len >> (4 * k)) != 0) ndig = k + 1;
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 2)) encoded.insert(encoded.size(), "0");
      for (int k = ndig - 1; k >= 0; k--)
        encoded.insert(encoded.size(), hex_char(chunk_len[4 * k +: 4]));
      encoded.insert(encoded.size(), CHAR_CR);
      encoded.insert(encoded.size(), CHAR_LF);
      if (chunk_len > 60) begin
        // huge chunk: only its first few data bytes, the next body interrupts it
        repeat ($urandom_range(0, 4))
          encoded.insert(encoded.size(), 8'($urandom_range(255)));
        truncated = 1'b1;
        break;
      end
      repeat (chunk_len) encoded.insert(encoded.size(), 8'($urandom_range(255)));
      encoded.insert(encoded.size(), CHAR_CR);
      encoded.insert(encoded.size(), CHAR_LF);
    end
    if (!truncated) begin
      encoded.insert(encoded.size(), "0");
      encoded.insert(encoded.size(), CHAR_CR);
      encoded.insert(encoded.size(), CHAR_LF);
      encoded.insert(encoded.size(), 8'($urandom_range(255)));
      encoded.insert(encoded.size(), 8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 12)
      encoded[$urandom_range(encoded.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(99) < 8) begin
      cut = $urandom_range(1, encoded.size());
      while (encoded.size() > cut) void'(encoded.pop_back());
      truncated = 1'b1;
    end
    sent = encoded.size();
    foreach (encoded[i]) send_request(i == 0, encoded[i]);
    // bytes after the end are ignored by the block and not counted
    if (!truncated)
      repeat ($urandom_range(0, 2)) send_request(1'b0, 8'($urandom_range(255)));
  endtask

  task automatic run_random(input int target);
    int done, sent;
    done = 0;
    while (done < target) begin
      send_random_body(sent);
      done += sent;
    end
  endtask

  task automatic test_framing_cases();
    // well-formed body with a 0xff data byte and trailing bytes 0x00 and 0xff, then a byte after completion
    send_line(1'b1, "1");
    send_request(1'b0, 8'hff);
    send_request(1'b0, CHAR_CR);
    send_request(1'b0, CHAR_LF);
    send_line(1'b0, "0");
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hff);
    send_request(1'b0, "Z");
    // non-hex byte on the size line, then a sticky byte
    send_request(1'b1, "g");
    send_request(1'b0, "5");
    // size line with no digits
    send_line(1'b1, "");
    // CR on the size line followed by something other than LF
    send_request(1'b1, "F");
    send_request(1'b0, CHAR_CR);
    send_request(1'b0, "x");
    // data not followed by CR, then CR not followed by LF
    send_line(1'b1, "1");
    send_request(1'b0, 8'h5a);
    send_request(1'b0, "x");
    send_line(1'b1, "a");
    repeat (10) send_request(1'b0, 8'($urandom_range(255)));
    send_request(1'b0, CHAR_CR);
    send_request(1'b0, CHAR_CR);
  endtask

  task automatic test_zero_limit();
    write_max_body(32'h0000_0000);
    // any nonzero chunk is too large, an empty body still completes
    send_line(1'b1, "1");
    send_line(1'b1, "0");
    send_request(1'b0, 8'h55);
    send_request(1'b0, 8'haa);
    run_random(50);
  endtask

  task automatic test_size_extremes();
    write_max_body(32'hffff_ffff);
    // largest chunk that fits, then a size of 2^32
    send_line(1'b1, "FFFFFFFF");
    repeat (3) send_request(1'b0, 8'($urandom_range(255)));
    send_line(1'b1, "100000000");
    run_random(80);
  endtask

  task automatic test_small_limit();
    write_max_body(32'd20);
    run_random(240);
  endtask

  task automatic test_reset_limit_traffic();
    write_max_body(MAX_BODY_RESET);
    run_random(280);
  endtask

  task automatic test_full_rate_traffic();
    run_random(200);
  endtask

  // long result hold-off while requests keep coming, so the input side backs up
  task automatic test_output_stall();
    hold_req = ~hold_req;
    run_random(100);
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.new_message <= 1'b0;
    in_ch.data_byte   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    in_idle_pct  = 10;
    out_idle_pct = 58;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    max_body = MAX_BODY_RESET;
    clear_framing();

    test_framing_cases();
    test_zero_limit();
    test_size_extremes();
    test_small_limit();
    in_idle_pct  = 58;
    out_idle_pct = 10;
    test_reset_limit_traffic();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_full_rate_traffic();
    test_output_stall();
    drain_results();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/hcbd_pkg.sv
src/hcbd_ifs.sv
src/hcbd_in_stage.sv
src/hcbd_core.sv
src/http_chunked_body_decoder_unit.sv
src/hcbd_checker.sv
dv/tb.sv
